// ----- hdl/ptt_pkg.sv -----
// ptt_pkg: shared types and codes for the periodic task timer table.
// Used by ptt_slot_unit, periodic_task_timer_table and ptt_checker.
// No dependencies.
`default_nettype none

package ptt_pkg;

   // Command codes on req_op
   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_REMOVE  = 3'd1;
   localparam logic [2:0] OP_SET_INT = 3'd2;
   localparam logic [2:0] OP_TICK    = 3'd3;
   localparam logic [2:0] OP_POLL    = 3'd4;

   // Status codes on rsp_status
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_DUP      = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_BADINT   = 3'd4;
   localparam logic [2:0] ST_RESERVED = 3'd5;

   // Configuration register indexes
   localparam logic REG_MIN_INTERVAL = 1'b0;
   localparam logic REG_MAX_INTERVAL = 1'b1;

   // Reserved id that marks a free slot
   localparam logic [7:0] FREE_ID = 8'hFF;

   // Poll reports at most this many slots
   localparam int MAX_OUT = 8;
   localparam int CNT_W   = $clog2(MAX_OUT);

   // One slot as held in the slot RAM
   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] interval;
      logic [15:0] remaining;
   } slot_word_type;

   localparam int WORD_W = $bits(slot_word_type);

   // Verdict of the slot unit on the slot under evaluation
   typedef struct packed {
      logic          hit;       // lookup match (remove, set) or duplicate (add)
      logic          free;      // slot holds no task
      logic          wr;        // write the slot word back
      slot_word_type wr_word;
      logic          set_pend;  // count reached zero
      logic          emit;      // poll reports this slot
   } slot_eval_type;

endpackage

`default_nettype wire

// ----- hdl/ptt_ram.sv -----
// ptt_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module ptt_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/ptt_slot_unit.sv -----
// ptt_slot_unit: shared compare and decrement unit applied to one slot per step.
// Depends on ptt_pkg.
`default_nettype none

module ptt_slot_unit (
   input  wire logic                  [2:0]  op,
   input  wire logic                  [7:0]  task_id,
   input  wire logic                  [15:0] interval,
   input  wire logic                         live,
   input  wire logic                         pending,
   input  wire ptt_pkg::slot_word_type       slot,
   output      ptt_pkg::slot_eval_type       eval
);

   logic        id_eq;
   logic [15:0] rem_dec;

   // A free slot matches only the reserved id
   assign id_eq   = live ? (slot.id == task_id) : (task_id == ptt_pkg::FREE_ID);
   assign rem_dec = slot.remaining - 16'd1;

   always_comb begin
      eval          = '0;
      eval.free     = !live;
      eval.wr_word  = slot;
      case (op)
         ptt_pkg::OP_ADD: begin
            eval.hit = live && (slot.id == task_id);
         end
         ptt_pkg::OP_REMOVE: begin
            eval.hit = id_eq;
         end
         ptt_pkg::OP_SET_INT: begin
            eval.hit              = id_eq;
            eval.wr               = id_eq;
            eval.wr_word.interval = interval;
         end
         ptt_pkg::OP_TICK: begin
            // count down live slots that have not fired yet
            eval.wr                = live && !pending;
            eval.wr_word.remaining = rem_dec;
            eval.set_pend          = live && !pending && (rem_dec == 16'd0);
         end
         ptt_pkg::OP_POLL: begin
            // report and reload
            eval.emit              = live && pending;
            eval.wr                = live && pending;
            eval.wr_word.remaining = slot.interval;
         end
         default: begin
            eval.hit = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/periodic_task_timer_table.sv -----
// periodic_task_timer_table: top level, sequencer, slot flags and result register.
// Depends on ptt_pkg, ptt_ram and ptt_slot_unit.
//
//   channel   direction  ports                                      transfer when
//   req       in         req_op, req_task_id, req_interval           req_valid & req_ready
//   rsp       out        rsp_status, rsp_fired_id, rsp_fired, rsp_last  rsp_valid & rsp_ready
//   csr       in         csr_index, csr_wr_data                      csr_wr_en
//
// Each command walks the slot RAM one slot at a time: a read step, then an evaluate
// step in the shared slot unit. Remove and set interval stop at the first match.
// Rejected commands answer without a walk. Poll stops on each fired slot while rsp is stalled.
// On reset the live and pending flags clear; the slot RAM is not swept.
`default_nettype none

module periodic_task_timer_table #(
   parameter int SLOTS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [2:0]  req_op,
   input  wire logic [7:0]  req_task_id,
   input  wire logic [15:0] req_interval,
   // result channel
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [2:0]  rsp_status,
   output      logic [7:0]  rsp_fired_id,
   output      logic        rsp_fired,
   output      logic        rsp_last,
   // configuration port
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wr_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_PROC   = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [2:0]                   op_ff;
   logic [7:0]                   id_ff;
   logic [15:0]                  iv_ff;
   logic [2:0]                   status_ff, status_in;
   logic                         found_ff, found_in;
   logic [IDX_W-1:0]             free_idx_ff, free_idx_in;
   logic [ptt_pkg::CNT_W-1:0]    emit_cnt_ff, emit_cnt_in;
   logic [SLOTS-1:0]             live_ff, live_in;
   logic [SLOTS-1:0]             pend_ff, pend_in;
   logic [15:0]                  min_ff, max_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [2:0]                   rsp_status_ff, rsp_status_in;
   logic [7:0]                   rsp_fired_id_ff, rsp_fired_id_in;
   logic                         rsp_fired_ff, rsp_fired_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         accept;
   logic                         out_free;
   logic                         interval_ok;
   logic                         more_above;
   logic                         last_slot;
   logic                         poll_last;

   logic                         ram_wr_en;
   logic [IDX_W-1:0]             ram_wr_addr;
   ptt_pkg::slot_word_type       ram_wr_data;
   logic                         ram_rd_en;
   ptt_pkg::slot_word_type       ram_rd_data;
   ptt_pkg::slot_eval_type       eval;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_slot = (idx_ff == LAST_IDX);
   assign interval_ok = (req_interval >= min_ff) && (req_interval <= max_ff);

   // any live pending slot above the current one
   always_comb begin
      more_above = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
         if (j > int'(idx_ff)) begin
            more_above = more_above | (live_ff[j] & pend_ff[j]);
         end
      end
   end

   assign poll_last = !more_above || (emit_cnt_ff == ptt_pkg::CNT_W'(ptt_pkg::MAX_OUT - 1));

   ptt_ram #(
      .WIDTH (ptt_pkg::WORD_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   ptt_slot_unit u_slot_unit (
      .op       (op_ff),
      .task_id  (id_ff),
      .interval (iv_ff),
      .live     (live_ff[idx_ff]),
      .pending  (pend_ff[idx_ff]),
      .slot     (ram_rd_data),
      .eval     (eval)
   );

   // Sequencer and slot bookkeeping
   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      status_in       = status_ff;
      found_in        = found_ff;
      free_idx_in     = free_idx_ff;
      emit_cnt_in     = emit_cnt_ff;
      live_in         = live_ff;
      pend_in         = pend_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = idx_ff;
      ram_wr_data     = eval.wr_word;
      ram_rd_en       = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_fired_id_in = rsp_fired_id_ff;
      rsp_fired_in    = rsp_fired_ff;
      rsp_last_in     = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in      = '0;
               found_in    = 1'b0;
               emit_cnt_in = '0;
               status_in   = ptt_pkg::ST_OK;
               state_in    = S_READ;
               if (req_op == ptt_pkg::OP_ADD && req_task_id == ptt_pkg::FREE_ID) begin
                  status_in = ptt_pkg::ST_RESERVED;
                  state_in  = S_RESP;
               end else if ((req_op == ptt_pkg::OP_ADD || req_op == ptt_pkg::OP_SET_INT)
                            && !interval_ok) begin
                  status_in = ptt_pkg::ST_BADINT;
                  state_in  = S_RESP;
               end else if (req_op > ptt_pkg::OP_POLL) begin
                  state_in = S_RESP;
               end
            end
         end

         S_READ: begin
            ram_rd_en = 1'b1;
            state_in  = S_PROC;
         end

         S_PROC: begin
            // advance to the next slot unless an outcome ends the walk
            state_in = last_slot ? S_RESP : S_READ;
            idx_in   = idx_ff + IDX_W'(1);
            case (op_ff)
               ptt_pkg::OP_ADD: begin
                  if (eval.hit) begin
                     status_in = ptt_pkg::ST_DUP;
                     state_in  = S_RESP;
                  end else begin
                     if (eval.free && !found_ff) begin
                        found_in    = 1'b1;
                        free_idx_in = idx_ff;
                     end
                     if (last_slot) begin
                        state_in = S_COMMIT;
                     end
                  end
               end
               ptt_pkg::OP_REMOVE: begin
                  if (eval.hit) begin
                     live_in[idx_ff] = 1'b0;
                     state_in        = S_RESP;
                  end else if (last_slot) begin
                     status_in = ptt_pkg::ST_NOTFOUND;
                  end
               end
               ptt_pkg::OP_SET_INT: begin
                  if (eval.hit) begin
                     ram_wr_en = 1'b1;
                     state_in  = S_RESP;
                  end else if (last_slot) begin
                     status_in = ptt_pkg::ST_NOTFOUND;
                  end
               end
               ptt_pkg::OP_TICK: begin
                  ram_wr_en = eval.wr;
                  if (eval.set_pend) begin
                     pend_in[idx_ff] = 1'b1;
                  end
               end
               ptt_pkg::OP_POLL: begin
                  if (eval.emit) begin
                     if (out_free) begin
                        ram_wr_en       = 1'b1;
                        pend_in[idx_ff] = 1'b0;
                        emit_cnt_in     = emit_cnt_ff + ptt_pkg::CNT_W'(1);
                        rsp_valid_in    = 1'b1;
                        rsp_status_in   = ptt_pkg::ST_OK;
                        rsp_fired_id_in = ram_rd_data.id;
                        rsp_fired_in    = 1'b1;
                        rsp_last_in     = poll_last;
                        if (poll_last) begin
                           state_in = S_IDLE;
                        end
                     end else begin
                        // hold on this slot until the result register drains
                        state_in = S_PROC;
                        idx_in   = idx_ff;
                     end
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         S_COMMIT: begin
            // fill the first free slot found during the walk
            state_in = S_RESP;
            if (found_ff) begin
               ram_wr_en                = 1'b1;
               ram_wr_addr              = free_idx_ff;
               ram_wr_data.id           = id_ff;
               ram_wr_data.interval     = iv_ff;
               ram_wr_data.remaining    = iv_ff;
               live_in[free_idx_ff]     = 1'b1;
               pend_in[free_idx_ff]     = 1'b0;
               status_in                = ptt_pkg::ST_OK;
            end else begin
               status_in = ptt_pkg::ST_FULL;
            end
         end

         S_RESP: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_fired_id_in = 8'd0;
               rsp_fired_in    = 1'b0;
               rsp_last_in     = 1'b1;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         emit_cnt_ff  <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         emit_cnt_ff  <= emit_cnt_in;
         idx_ff       <= idx_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 16'd1;
         max_ff <= 16'hFFFF;
      end else if (csr_wr_en) begin
         case (csr_index)
            ptt_pkg::REG_MIN_INTERVAL: min_ff <= csr_wr_data;
            ptt_pkg::REG_MAX_INTERVAL: max_ff <= csr_wr_data;
            default: min_ff <= min_ff;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_op;
         id_ff <= req_task_id;
         iv_ff <= req_interval;
      end
      status_ff       <= status_in;
      free_idx_ff     <= free_idx_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_fired_id_ff <= rsp_fired_id_in;
      rsp_fired_ff    <= rsp_fired_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_fired_id = rsp_fired_id_ff;
   assign rsp_fired    = rsp_fired_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

// ----- hdl/ptt_checker.sv -----
// ptt_checker: port-level assertions for periodic_task_timer_table, bound to the top.
// Depends on ptt_pkg.
`default_nettype none

module ptt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [7:0]  rsp_fired_id,
   input wire logic        rsp_fired,
   input wire logic        rsp_last
);

   // Hold a stalled result transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_fired_id) && $stable(rsp_fired) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   // Drop ready after a request transfer: one item at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready stayed high after a request transfer");

   // A plain status result closes its sequence and carries no id
   a_plain_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_last && (rsp_fired_id == 8'd0))
      else $error("status result without last or with an id");

   // Fired reports always carry the ok status
   a_fired_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> (rsp_status == ptt_pkg::ST_OK))
      else $error("fired report with a non-ok status");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_status   (rsp_status),
   .rsp_fired_id (rsp_fired_id),
   .rsp_fired    (rsp_fired),
   .rsp_last     (rsp_last)
);

`default_nettype wire

// ----- bench/tb.sv -----
// tb: self-checking bench for periodic_task_timer_table (slot table, tick, poll, csr range).
// Depends on ptt_pkg and the RTL top; holds its own slot table to predict every response.
`timescale 1ns / 1ps

// One response beat as seen on the rsp channel
typedef struct packed {
   logic [2:0] status;
   logic [7:0] fired_id;
   logic       fired;
   logic       last;
} timer_rsp_type;

// Shadow slot table plus the queue of responses it still owes
class timer_table_scoreboard;
   localparam int SLOTS = 8;

   logic [7:0]    slot_tag [SLOTS];
   logic [15:0]   slot_period [SLOTS];
   logic [15:0]   slot_count [SLOTS];
   logic          slot_due [SLOTS];
   logic [15:0]   lo_limit;
   logic [15:0]   hi_limit;
   timer_rsp_type awaited_rsp [$];
   int            errors;

   function new();
      errors   = 0;
      lo_limit = 16'd1;
      hi_limit = 16'hFFFF;
      for (int i = 0; i < SLOTS; i++) begin
         slot_tag[i]    = ptt_pkg::FREE_ID;
         slot_period[i] = '0;
         slot_count[i]  = '0;
         slot_due[i]    = 1'b0;
      end
   endfunction

   function void write_reg(logic idx, logic [15:0] val);
      if (idx == ptt_pkg::REG_MIN_INTERVAL) lo_limit = val;
      else hi_limit = val;
   endfunction

   function int lookup_tag(logic [7:0] tag);
      for (int i = 0; i < SLOTS; i++)
         if (slot_tag[i] == tag) return i;
      return -1;
   endfunction

   // Apply one accepted command to the shadow table and queue its responses
   function void accept_command(logic [2:0] op, logic [7:0] tag, logic [15:0] period);
      logic [2:0] st;
      int         s;
      int         fired_slots [$];
      logic       in_range;
      st       = ptt_pkg::ST_OK;
      in_range = (period >= lo_limit) && (period <= hi_limit);
      case (op)
         ptt_pkg::OP_ADD: begin
            if (tag == ptt_pkg::FREE_ID) st = ptt_pkg::ST_RESERVED;
            else if (!in_range) st = ptt_pkg::ST_BADINT;
            else if (lookup_tag(tag) >= 0) st = ptt_pkg::ST_DUP;
            else begin
               s = lookup_tag(ptt_pkg::FREE_ID);
               if (s < 0) st = ptt_pkg::ST_FULL;
               else begin
                  slot_tag[s]    = tag;
                  slot_period[s] = period;
                  slot_count[s]  = period;
                  slot_due[s]    = 1'b0;
               end
            end
         end
         ptt_pkg::OP_REMOVE: begin
            // a reserved id lands on a free slot, which simply stays free
            s = lookup_tag(tag);
            if (s < 0) st = ptt_pkg::ST_NOTFOUND;
            else slot_tag[s] = ptt_pkg::FREE_ID;
         end
         ptt_pkg::OP_SET_INT: begin
            if (!in_range) st = ptt_pkg::ST_BADINT;
            else begin
               s = lookup_tag(tag);
               if (s < 0) st = ptt_pkg::ST_NOTFOUND;
               else slot_period[s] = period;
            end
         end
         ptt_pkg::OP_TICK: begin
            // count down live, non-pending slots; zero wraps within 16 bits
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_tag[i] != ptt_pkg::FREE_ID && !slot_due[i]) begin
                  slot_count[i] = slot_count[i] - 16'd1;
                  if (slot_count[i] == 16'd0) slot_due[i] = 1'b1;
               end
            end
         end
         ptt_pkg::OP_POLL: begin
            for (int i = 0; i < SLOTS && fired_slots.size() < ptt_pkg::MAX_OUT; i++) begin
               if (slot_tag[i] != ptt_pkg::FREE_ID && slot_due[i]) begin
                  fired_slots.push_back(i);
                  slot_count[i] = slot_period[i];
                  slot_due[i]   = 1'b0;
               end
            end
            if (fired_slots.size() == 0) begin
               awaited_rsp.push_back('{ptt_pkg::ST_OK, 8'd0, 1'b0, 1'b1});
            end else begin
               foreach (fired_slots[k])
                  awaited_rsp.push_back('{ptt_pkg::ST_OK, slot_tag[fired_slots[k]], 1'b1,
                                          k == fired_slots.size() - 1});
            end
            return;
         end
         default: ;
      endcase
      awaited_rsp.push_back('{st, 8'd0, 1'b0, 1'b1});
   endfunction

   function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // Compare one response transfer with the oldest owed response
   function void match_result(timer_rsp_type got);
      timer_rsp_type want;
      if (awaited_rsp.size() == 0) begin
         $display("%0t: unexpected response, expected none, actual status %0d id %0d",
                  $time, got.status, got.fired_id);
         errors++;
         return;
      end
      want = awaited_rsp.pop_front();
      check_field("rsp_status", want.status, got.status);
      check_field("rsp_fired_id", want.fired_id, got.fired_id);
      check_field("rsp_fired", want.fired, got.fired);
      check_field("rsp_last", want.last, got.last);
   endfunction
endclass

module tb;

   localparam int SLOTS       = 8;
   localparam int IDLE_LIMIT  = 3000;
   localparam int PHASE_ITEMS = 47;
   localparam int TAIL_CYCLES = 2 * SLOTS + 4;

   // op codes the block treats as no-ops
   localparam logic [2:0] OP_NOP_LO = 3'd5;
   localparam logic [2:0] OP_NOP_HI = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_op = '0;
   logic [7:0]  req_task_id = '0;
   logic [15:0] req_interval = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_fired_id;
   logic        rsp_fired;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = ptt_pkg::REG_MIN_INTERVAL;
   logic [15:0] csr_wr_data = '0;

   timer_table_scoreboard sb = new();

   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   int          stall_left = 0;
   int          idle_cycles = 0;

   // csr settings per random phase: {min, max}
   logic [15:0] phase_lo [7] = '{16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd9, 16'd0, 16'd1};
   logic [15:0] phase_hi [7] = '{16'd6, 16'd4, 16'd2, 16'hFFFF, 16'd3, 16'hFFFF, 16'd1};

   periodic_task_timer_table #(.SLOTS(SLOTS)) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_task_id  (req_task_id),
      .req_interval (req_interval),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_fired_id (rsp_fired_id),
      .rsp_fired    (rsp_fired),
      .rsp_last     (rsp_last),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Favor a small id pool so duplicates, lookups and a full table all occur
   function automatic logic [7:0] pick_tag();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return 8'($urandom_range(0, 11));
      if (r < 92) return ptt_pkg::FREE_ID;
      return 8'($urandom_range(0, 255));
   endfunction

   // Mostly in range and short, some anywhere, some just past a bound
   function automatic logic [15:0] pick_period();
      int r;
      int span;
      r = $urandom_range(0, 9);
      if (r < 7 && sb.lo_limit <= sb.hi_limit) begin
         span = sb.hi_limit - sb.lo_limit;
         if (span > 5) span = 5;
         return sb.lo_limit + 16'($urandom_range(0, span));
      end
      if (r == 9) return $urandom_range(0, 1) ? sb.lo_limit - 16'd1 : sb.hi_limit + 16'd1;
      return 16'($urandom_range(0, 65535));
   endfunction

   // Drive one request from a falling edge and hold it until the transfer
   task automatic send_request(logic [2:0] op, logic [7:0] tag, logic [15:0] period);
      int gap;
      gap = req_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_task_id  <= tag;
      req_interval <= period;
      do @(posedge clock); while (!req_ready);
      sb.accept_command(op, tag, period);
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.awaited_rsp.size() != 0) @(negedge clock);
   endtask

   // Write both range registers, min then max, block idle
   task automatic write_range(logic [15:0] lo, logic [15:0] hi);
      csr_wr_en   <= 1'b1;
      csr_index   <= ptt_pkg::REG_MIN_INTERVAL;
      csr_wr_data <= lo;
      @(negedge clock);
      sb.write_reg(ptt_pkg::REG_MIN_INTERVAL, lo);
      csr_index   <= ptt_pkg::REG_MAX_INTERVAL;
      csr_wr_data <= hi;
      @(negedge clock);
      sb.write_reg(ptt_pkg::REG_MAX_INTERVAL, hi);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_random();
      int r;
      r = $urandom_range(0, 99);
      if (r < 34) send_request(ptt_pkg::OP_TICK, pick_tag(), 16'($urandom_range(0, 65535)));
      else if (r < 54) send_request(ptt_pkg::OP_POLL, pick_tag(),
                                    16'($urandom_range(0, 65535)));
      else if (r < 73) send_request(ptt_pkg::OP_ADD, pick_tag(), pick_period());
      else if (r < 83) send_request(ptt_pkg::OP_REMOVE, pick_tag(),
                                    16'($urandom_range(0, 65535)));
      else if (r < 95) send_request(ptt_pkg::OP_SET_INT, pick_tag(), pick_period());
      else send_request(3'($urandom_range(OP_NOP_LO, OP_NOP_HI)), pick_tag(),
                        16'($urandom_range(0, 65535)));
   endtask

   // Stall the response side in bursts, with calm stretches
   always @(negedge clock) begin
      if ($urandom_range(0, 49) == 0) rsp_calm = ~rsp_calm;
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!rsp_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   // Check every response transfer
   always @(posedge clock) begin
      timer_rsp_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.status   = rsp_status;
         seen.fired_id = rsp_fired_id;
         seen.fired    = rsp_fired;
         seen.last     = rsp_last;
         sb.match_result(seen);
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset range, field extremes and corner cases
      send_request(ptt_pkg::OP_ADD, ptt_pkg::FREE_ID, 16'd5);        // reserved id
      send_request(ptt_pkg::OP_ADD, 8'd0, 16'd0);                    // below min
      send_request(ptt_pkg::OP_ADD, 8'd0, 16'd1);
      send_request(ptt_pkg::OP_ADD, 8'd0, 16'd3);                    // duplicate
      send_request(ptt_pkg::OP_ADD, 8'd254, 16'hFFFF);
      send_request(ptt_pkg::OP_REMOVE, ptt_pkg::FREE_ID, 16'hFFFF);  // hits a free slot
      send_request(ptt_pkg::OP_SET_INT, ptt_pkg::FREE_ID, 16'd7);    // sets a free slot
      send_request(ptt_pkg::OP_SET_INT, 8'd77, 16'd2);               // not found
      send_request(ptt_pkg::OP_SET_INT, 8'd0, 16'd2);                // takes effect at reload
      send_request(ptt_pkg::OP_TICK, 8'd0, 16'd0);
      send_request(ptt_pkg::OP_POLL, 8'd0, 16'd0);
      send_request(ptt_pkg::OP_POLL, 8'd0, 16'd0);                   // nothing pending
      for (int k = 1; k <= 6; k++) send_request(ptt_pkg::OP_ADD, 8'(k), 16'd1);
      send_request(ptt_pkg::OP_ADD, 8'd7, 16'd1);                    // table full
      send_request(ptt_pkg::OP_REMOVE, ptt_pkg::FREE_ID, 16'd0);     // no free slot
      send_request(ptt_pkg::OP_SET_INT, ptt_pkg::FREE_ID, 16'd4);    // no free slot
      send_request(ptt_pkg::OP_TICK, 8'd255, 16'hFFFF);
      send_request(ptt_pkg::OP_POLL, 8'd0, 16'd0);                   // six fire at once
      send_request(OP_NOP_LO, 8'd0, 16'd0);
      send_request(OP_NOP_HI, 8'd255, 16'hFFFF);

      // Random phases, each under its own interval range
      foreach (phase_lo[p]) begin
         drain_responses();
         write_range(phase_lo[p], phase_hi[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0) req_calm = ~req_calm;
            send_random();
         end
      end

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.awaited_rsp.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
